### sv/json_string_unescaper_defines.svh
// Assertion macros shared by the JSON string unescaper RTL.
`ifndef JSON_STRING_UNESCAPER_DEFINES_SVH
`define JSON_STRING_UNESCAPER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define JSU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define JSU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/jsu_pkg.sv
// Shared types and constants of the JSON string unescaper.
`default_nettype none

package jsu_pkg;

  localparam int MAX_RESULTS = 5;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // Results caused by one input beat, in output order.
  typedef struct packed {
    logic [CNT_W-1:0]                 count;
    logic [MAX_RESULTS-1:0][7:0]      bytes;
    logic [MAX_RESULTS-1:0][1:0]      kinds;
  } result_t;

endpackage

`default_nettype wire

### sv/jsu_decoder.sv
// Escape decoder: parse state and per-beat result list.
`default_nettype none

module jsu_decoder (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      data_byte,
  input  wire logic            end_of_text,
  output jsu_pkg::result_t     res
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_STR     = 3'd1,
    M_ESC     = 3'd2,
    M_HEX1    = 3'd3,
    M_NEED_BS = 3'd4,
    M_NEED_U  = 3'd5,
    M_HEX2    = 3'd6
  } mode_t;

  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] b;
  } utf8_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'h0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic utf8_t utf8_enc(input logic [20:0] cp);
    utf8_t u;
    u = '0;
    if (cp < 21'h80) begin
      u.len  = 3'd1;
      u.b[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      u.len  = 3'd2;
      u.b[0] = {3'b110, cp[10:6]};
      u.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      u.len  = 3'd3;
      u.b[0] = {4'b1110, cp[15:12]};
      u.b[1] = {2'b10, cp[11:6]};
      u.b[2] = {2'b10, cp[5:0]};
    end else begin
      u.len  = 3'd4;
      u.b[0] = {5'b11110, cp[20:18]};
      u.b[1] = {2'b10, cp[17:12]};
      u.b[2] = {2'b10, cp[11:6]};
      u.b[3] = {2'b10, cp[5:0]};
    end
    return u;
  endfunction

  mode_t       mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [15:0] code_accum, code_accum_next;
  logic [9:0]  high_bits, high_bits_next;

  logic [4:0]  hv;
  logic [15:0] acc_shift;
  logic [20:0] pair_cp;
  utf8_t       data;
  logic        err, done, term;
  kind_t       term_kind;

  assign hv        = hex_val(data_byte);
  assign acc_shift = {code_accum[11:0], hv[3:0]};
  // Surrogate pair: low half minus 0xDC00 is just its low ten bits.
  assign pair_cp   = 21'h10000 + {1'b0, high_bits, acc_shift[9:0]};

  always_comb begin
    mode_next       = mode;
    hex_count_next  = hex_count;
    code_accum_next = code_accum;
    high_bits_next  = high_bits;
    data            = '0;
    err             = 1'b0;
    done            = 1'b0;

    case (mode)
      M_IDLE: begin
        if (data_byte == CH_QUOTE) mode_next = M_STR;
        else err = 1'b1;
      end
      M_STR: begin
        if (data_byte == CH_QUOTE) done = 1'b1;
        else if (data_byte < 8'h20) err = 1'b1;
        else if (data_byte == CH_BSL) mode_next = M_ESC;
        else begin
          data.len  = 3'd1;
          data.b[0] = data_byte;
        end
      end
      M_ESC: begin
        mode_next = M_STR;
        data.len  = 3'd1;
        case (data_byte)
          CH_QUOTE, CH_BSL, CH_SLASH: data.b[0] = data_byte;
          CH_B: data.b[0] = 8'h08;
          CH_F: data.b[0] = 8'h0c;
          CH_N: data.b[0] = 8'h0a;
          CH_R: data.b[0] = 8'h0d;
          CH_T: data.b[0] = 8'h09;
          CH_U: begin
            data.len        = 3'd0;
            mode_next       = M_HEX1;
            hex_count_next  = 2'd0;
            code_accum_next = 16'h0;
          end
          default: begin
            data.len = 3'd0;
            err      = 1'b1;
          end
        endcase
      end
      M_HEX1, M_HEX2: begin
        if (!hv[4]) begin
          err = 1'b1;
        end else if (hex_count != 2'd3) begin
          hex_count_next  = hex_count + 2'd1;
          code_accum_next = acc_shift;
        end else begin
          hex_count_next  = 2'd0;
          code_accum_next = 16'h0;
          if (mode == M_HEX1) begin
            if (acc_shift == 16'h0 || (acc_shift >= 16'hdc00 && acc_shift <= 16'hdfff)) begin
              err = 1'b1;
            end else if (acc_shift >= 16'hd800 && acc_shift <= 16'hdbff) begin
              high_bits_next = acc_shift[9:0];
              mode_next      = M_NEED_BS;
            end else begin
              data      = utf8_enc({5'b0, acc_shift});
              mode_next = M_STR;
            end
          end else begin
            if (acc_shift < 16'hdc00 || acc_shift > 16'hdfff) begin
              err = 1'b1;
            end else begin
              data      = utf8_enc(pair_cp);
              mode_next = M_STR;
            end
          end
        end
      end
      M_NEED_BS: begin
        if (data_byte == CH_BSL) mode_next = M_NEED_U;
        else err = 1'b1;
      end
      M_NEED_U: begin
        if (data_byte == CH_U) begin
          mode_next       = M_HEX2;
          hex_count_next  = 2'd0;
          code_accum_next = 16'h0;
        end else begin
          err = 1'b1;
        end
      end
      default: err = 1'b1;
    endcase

    // Input ran out inside the string.
    if (!err && !done && end_of_text) err = 1'b1;

    if (err || done) begin
      mode_next       = M_IDLE;
      hex_count_next  = 2'd0;
      code_accum_next = 16'h0;
      high_bits_next  = 10'h0;
    end
  end

  assign term      = err || done;
  assign term_kind = err ? KIND_ERR : KIND_DONE;

  always_comb begin
    res.count = CNT_W'(data.len) + CNT_W'(term);
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res.bytes[i] = 8'h0;
      res.kinds[i] = KIND_DATA;
      if (i < 4 && 3'(i) < data.len) res.bytes[i] = data.b[2'(i)];
      if (term && 3'(i) == data.len) res.kinds[i] = term_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      hex_count  <= 2'd0;
      code_accum <= 16'h0;
      high_bits  <= 10'h0;
    end else if (accept) begin
      mode       <= mode_next;
      hex_count  <= hex_count_next;
      code_accum <= code_accum_next;
      high_bits  <= high_bits_next;
    end
  end

`include "json_string_unescaper_defines.svh"

  `JSU_ASSERT_NEXT(a_term_clears, clk, rst, accept && term, mode == M_IDLE && hex_count == 2'd0 && code_accum == 16'h0, "state not cleared after done or error")
  `JSU_ASSERT_NOW(a_hex_mode, clk, rst, hex_count != 2'd0, mode == M_HEX1 || mode == M_HEX2, "hex count outside a hex group")

endmodule

`default_nettype wire

### sv/jsu_emitter.sv
// Result buffer: holds one beat's results, sends one per cycle unless stalled.
`default_nettype none

module jsu_emitter (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire jsu_pkg::result_t res,
  output logic                  busy,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [7:0]            out_byte,
  output logic [1:0]            kind,
  output logic                  last
);
  import jsu_pkg::*;

  logic [CNT_W-1:0]            remain;
  logic [MAX_RESULTS-1:0][7:0] bytes;
  logic [MAX_RESULTS-1:0][1:0] kinds;
  logic                        take;

  assign out_valid = remain != '0;
  assign take      = out_valid && !out_stall;
  assign last      = remain == CNT_W'(1);
  assign out_byte  = bytes[0];
  assign kind      = kinds[0];
  // Can load when empty, or when the final beat leaves this cycle.
  assign busy      = out_valid && !(last && take);

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= '0;
    end else if (load) begin
      remain <= res.count;
    end else if (take) begin
      remain <= remain - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      bytes <= res.bytes;
      kinds <= res.kinds;
    end else if (take) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        bytes[i] <= bytes[i+1];
        kinds[i] <= kinds[i+1];
      end
    end
  end

`include "json_string_unescaper_defines.svh"

  `JSU_ASSERT_NOW(a_term_is_last, clk, rst, out_valid && kind != KIND_DATA, last, "done or error beat not marked last")
  `JSU_ASSERT_NEXT(a_drains, clk, rst, take && last && !load, !out_valid, "buffer not empty after last beat")

endmodule

`default_nettype wire

### sv/json_string_unescaper.sv
// Top level of the JSON string unescaper.
// Decodes one quoted JSON string given one raw byte per input beat, starting
// with the opening quote. Each beat yields zero to five result beats: decoded
// bytes (kind 0), a done beat on the closing quote (kind 1) or an error beat
// (kind 2); last marks the final result of an input byte. Parsing state is
// updated on each accepted byte, and the results go to a registered buffer
// that sends one beat per cycle unless out_stall holds it off, so the block
// takes one byte per cycle while each byte gives at most one result and the
// output does not stall. A byte that gives more results holds the input off
// while the buffer drains, as for multi-byte UTF-8 from \u escapes or data
// plus an error at end of text. After done or error it awaits an open quote.
`default_nettype none

module json_string_unescaper (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_text,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic [1:0]      kind,
  output logic            last
);
  import jsu_pkg::*;

  result_t res;
  logic    busy;
  logic    accept;

  assign in_stall = busy;
  assign accept   = in_valid && !busy;

  jsu_decoder u_decoder (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (data_byte),
    .end_of_text (end_of_text),
    .res         (res)
  );

  jsu_emitter u_emitter (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .res       (res),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .kind      (kind),
    .last      (last)
  );

endmodule

`default_nettype wire

### dv/json_string_unescaper_checker.sv
// Result checker for the JSON string unescaper: predicts every beat and compares it.
module json_string_unescaper_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_text,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_byte,
  input  logic [1:0] kind,
  input  logic       last,
  output int         mismatches,
  output int         outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam logic [7:0] QUOTE  = 8'h22;
  localparam logic [7:0] BSLASH = 8'h5c;
  localparam logic [7:0] SLASH  = 8'h2f;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STRING,
    ST_ESCAPE,
    ST_HEX_HIGH,
    ST_WANT_BSLASH,
    ST_WANT_U,
    ST_HEX_LOW
  } parse_state_t;

  typedef struct packed {
    logic [7:0] value;
    kind_t      kind;
    logic       last;
  } beat_t;

  parse_state_t state;
  logic [1:0]   digits;
  logic [15:0]  accum;
  logic [9:0]   high_ten;

  beat_t decoded_q[$];
  beat_t staged[MAX_RESULTS];
  int    staged_n;
  beat_t want;

  function automatic void clear_parse();
    state    = ST_IDLE;
    digits   = '0;
    accum    = '0;
    high_ten = '0;
  endfunction

  function automatic void stage(input logic [7:0] v, input kind_t k);
    staged[staged_n] = '{value: v, kind: k, last: 1'b0};
    staged_n++;
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic void emit_utf8(input logic [20:0] code);
    if (code < 21'h80) begin
      stage(code[7:0], KIND_DATA);
    end else if (code < 21'h800) begin
      stage({3'b110, code[10:6]}, KIND_DATA);
      stage({2'b10, code[5:0]}, KIND_DATA);
    end else if (code < 21'h10000) begin
      stage({4'b1110, code[15:12]}, KIND_DATA);
      stage({2'b10, code[11:6]}, KIND_DATA);
      stage({2'b10, code[5:0]}, KIND_DATA);
    end else begin
      stage({5'b11110, code[20:18]}, KIND_DATA);
      stage({2'b10, code[17:12]}, KIND_DATA);
      stage({2'b10, code[11:6]}, KIND_DATA);
      stage({2'b10, code[5:0]}, KIND_DATA);
    end
  endfunction

  // Advances the parse by one raw byte and queues the beats it yields.
  function automatic void decode_byte(input logic [7:0] c, input logic eot);
    logic err;
    logic done;
    int   h;
    err      = 1'b0;
    done     = 1'b0;
    staged_n = 0;
    case (state)
      ST_IDLE: begin
        if (c == QUOTE) state = ST_STRING;
        else err = 1'b1;
      end
      ST_STRING: begin
        if (c == QUOTE) done = 1'b1;
        else if (c < 8'd32) err = 1'b1;
        else if (c == BSLASH) state = ST_ESCAPE;
        else stage(c, KIND_DATA);
      end
      ST_ESCAPE: begin
        state = ST_STRING;
        case (c)
          QUOTE, BSLASH, SLASH: stage(c, KIND_DATA);
          "b": stage(8'h08, KIND_DATA);
          "f": stage(8'h0c, KIND_DATA);
          "n": stage(8'h0a, KIND_DATA);
          "r": stage(8'h0d, KIND_DATA);
          "t": stage(8'h09, KIND_DATA);
          "u": begin
            state  = ST_HEX_HIGH;
            digits = '0;
            accum  = '0;
          end
          default: err = 1'b1;
        endcase
      end
      ST_HEX_HIGH, ST_HEX_LOW: begin
        h = hex_digit(c);
        if (h < 0) begin
          err = 1'b1;
        end else begin
          accum = {accum[11:0], h[3:0]};
          if (digits < 2'd3) begin
            digits++;
          end else begin
            digits = '0;
            if (state == ST_HEX_HIGH) begin
              // zero and a low surrogate cannot stand alone
              if (accum == 16'h0000 || accum[15:10] == 6'b110111) begin
                err = 1'b1;
              end else if (accum[15:10] == 6'b110110) begin
                high_ten = accum[9:0];
                state    = ST_WANT_BSLASH;
              end else begin
                emit_utf8({5'd0, accum});
                state = ST_STRING;
              end
            end else if (accum[15:10] != 6'b110111) begin
              err = 1'b1;
            end else begin
              emit_utf8(21'h10000 + {1'b0, high_ten, accum[9:0]});
              state = ST_STRING;
            end
            accum = '0;
          end
        end
      end
      ST_WANT_BSLASH: begin
        if (c == BSLASH) state = ST_WANT_U;
        else err = 1'b1;
      end
      ST_WANT_U: begin
        if (c == "u") begin
          state  = ST_HEX_LOW;
          digits = '0;
          accum  = '0;
        end else begin
          err = 1'b1;
        end
      end
      default: err = 1'b1;
    endcase

    // running out of text inside a string is an error after any data
    if (!err && !done && eot) err = 1'b1;
    if (err) stage(8'h00, KIND_ERR);
    else if (done) stage(8'h00, KIND_DONE);
    if (err || done) clear_parse();

    for (int i = 0; i < staged_n; i++) begin
      if (i == staged_n - 1) staged[i].last = 1'b1;
      decoded_q.push_back(staged[i]);
    end
  endfunction

  function automatic void flag_miss(input string what, input beat_t exp);
    if (mismatches < 10) begin
      $display("mismatch (%s): expected byte %h kind %0d last %0b, got byte %h kind %0d last %0b",
               what, exp.value, exp.kind, exp.last, out_byte, kind, last);
    end
    mismatches++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      decoded_q.delete();
      mismatches = 0;
    end else begin
      if (in_valid && !in_stall) decode_byte(data_byte, end_of_text);
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          flag_miss("no beat pending", '0);
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.value || kind !== want.kind || last !== want.last) begin
            flag_miss("wrong field", want);
          end
        end
      end
    end
    outstanding = decoded_q.size();
  end

endmodule

### dv/json_string_unescaper_test.sv
// Testbench top for the JSON string unescaper: clock, reset, byte stimulus and verdict.
module json_string_unescaper_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_BYTES = 100;
  localparam int HOLD_CYCLES = 120;

  localparam logic [7:0] QUOTE  = 8'h22;
  localparam logic [7:0] BSLASH = 8'h5c;
  localparam logic [7:0] SLASH  = 8'h2f;

  typedef enum int {
    F_CTRL,
    F_BAD_ESC,
    F_BAD_HEX,
    F_NUL,
    F_LONE_LOW,
    F_NO_BSLASH,
    F_NO_U,
    F_BAD_LOW
  } fault_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] data_byte;
  logic       end_of_text;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;
  int         mismatches;
  int         outstanding;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_len       = 0;
  int quiet_cycles   = 0;
  int phase_bytes    = 0;

  logic [7:0] text_q[$];

  json_string_unescaper dut (.*);

  json_string_unescaper_checker beat_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: a long hold-off when asked, otherwise random stalls.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        hold_len = hold_len - 1;
      end else begin
        out_stall <= (recv_stall_pct != 0 && $urandom_range(99, 0) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eot);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    end_of_text <= eot;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input bit eot_last);
    for (int i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], eot_last && i == text_q.size() - 1);
    end
    phase_bytes += text_q.size();
    text_q.delete();
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + nib;
    return ($urandom_range(1, 0) ? 8'h61 : 8'h41) + nib - 8'd10;
  endfunction

  function automatic void push_escape_u(input logic [15:0] v);
    text_q.push_back(BSLASH);
    text_q.push_back("u");
    for (int i = 3; i >= 0; i--) text_q.push_back(hex_char(v[i*4 +: 4]));
  endfunction

  // Range ends come up often so that boundary code points get exercised.
  function automatic logic [15:0] pick_code(input logic [15:0] lo, input logic [15:0] hi);
    case ($urandom_range(5, 0))
      0: return lo;
      1: return hi;
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic void push_piece();
    logic [7:0]  c;
    logic [15:0] v;
    case ($urandom_range(9, 0))
      0, 1, 2, 3: begin
        do c = 8'($urandom_range(255, 32));
        while (c == QUOTE || c == BSLASH);
        text_q.push_back(c);
      end
      4, 5: begin
        case ($urandom_range(7, 0))
          0: c = QUOTE;
          1: c = BSLASH;
          2: c = SLASH;
          3: c = "b";
          4: c = "f";
          5: c = "n";
          6: c = "r";
          default: c = "t";
        endcase
        text_q.push_back(BSLASH);
        text_q.push_back(c);
      end
      6: push_escape_u(pick_code(16'h0001, 16'h007f));
      7: push_escape_u(pick_code(16'h0080, 16'h07ff));
      8: begin
        v = pick_code(16'h0800, 16'hffff);
        if (v[15:11] == 5'b11011) v[14] = 1'b0;
        push_escape_u(v);
      end
      default: begin
        push_escape_u(pick_code(16'hd800, 16'hdbff));
        push_escape_u(pick_code(16'hdc00, 16'hdfff));
      end
    endcase
  endfunction

  // Appends a sequence that breaks the string at its last byte.
  function automatic void push_fault();
    logic [7:0]  c;
    logic [15:0] v;
    fault_t      f;
    f = fault_t'($urandom_range(7, 0));
    case (f)
      F_CTRL: text_q.push_back(8'($urandom_range(31, 0)));
      F_BAD_ESC: begin
        do c = 8'($urandom_range(255, 0));
        while (c == QUOTE || c == BSLASH || c == SLASH || c == "b" || c == "f" ||
               c == "n" || c == "r" || c == "t" || c == "u");
        text_q.push_back(BSLASH);
        text_q.push_back(c);
      end
      F_BAD_HEX: begin
        if ($urandom_range(1, 0)) push_escape_u(pick_code(16'hd800, 16'hdbff));
        text_q.push_back(BSLASH);
        text_q.push_back("u");
        repeat ($urandom_range(3, 0)) text_q.push_back(hex_char(4'($urandom_range(15, 0))));
        do c = 8'($urandom_range(255, 0));
        while ((c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F"));
        text_q.push_back(c);
      end
      F_NUL: push_escape_u(16'h0000);
      F_LONE_LOW: push_escape_u(pick_code(16'hdc00, 16'hdfff));
      F_NO_BSLASH: begin
        push_escape_u(pick_code(16'hd800, 16'hdbff));
        do c = 8'($urandom_range(255, 0));
        while (c == BSLASH);
        text_q.push_back(c);
      end
      F_NO_U: begin
        push_escape_u(pick_code(16'hd800, 16'hdbff));
        text_q.push_back(BSLASH);
        do c = 8'($urandom_range(255, 0));
        while (c == "u");
        text_q.push_back(c);
      end
      default: begin
        push_escape_u(pick_code(16'hd800, 16'hdbff));
        v = 16'($urandom_range(16'hffff, 0));
        if (v[15:10] == 6'b110111) v[15] = 1'b0;
        push_escape_u(v);
      end
    endcase
  endfunction

  task automatic make_string();
    int         r;
    bit         eot_last;
    logic [7:0] c;
    r        = $urandom_range(99, 0);
    eot_last = 1'b0;
    if (r >= 97) begin
      // stray byte outside any string
      do c = 8'($urandom_range(255, 0));
      while (c == QUOTE);
      text_q.push_back(c);
      eot_last = 1'($urandom_range(1, 0));
    end else begin
      text_q.push_back(QUOTE);
      repeat ($urandom_range(8, 0)) push_piece();
      if (r < 70) begin
        text_q.push_back(QUOTE);
        eot_last = ($urandom_range(4, 0) == 0);
      end else if (r < 82) begin
        push_fault();
      end else if (r < 90) begin
        // text runs out mid-string, sometimes inside an escape
        case ($urandom_range(3, 0))
          0: text_q.push_back(BSLASH);
          1: begin
            text_q.push_back(BSLASH);
            text_q.push_back("u");
            repeat ($urandom_range(3, 0)) text_q.push_back(hex_char(4'($urandom_range(15, 0))));
          end
          2: begin
            push_escape_u(pick_code(16'hd800, 16'hdbff));
            if ($urandom_range(1, 0)) text_q.push_back(BSLASH);
          end
          default: ;
        endcase
        eot_last = 1'b1;
      end else begin
        text_q.push_back(QUOTE);
        text_q[$urandom_range(text_q.size() - 1, 0)] = 8'($urandom_range(255, 0));
      end
    end
    send_text(eot_last);
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    data_byte   = 8'h00;
    end_of_text = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // stray NUL while idle, then a closed string with a plain high byte,
    // a simple escape and a two-byte code point
    text_q = '{8'h00, QUOTE, 8'hff, BSLASH, "n", BSLASH, "u", "0", "0", "e", "9", QUOTE};
    send_text(1'b0);
    // surrogate pair on the last byte of text: four data beats then an error
    text_q = '{QUOTE, BSLASH, "u", "D", "8", "3", "D", BSLASH, "u", "d", "E", "0", "0"};
    send_text(1'b1);

    for (int phase = 0; phase <= 4; phase++) begin
      in_valid <= 1'b0;
      wait (outstanding == 0);
      @(negedge clk);
      if (phase == 4) break;
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_len       = HOLD_CYCLES;
        end
        1: begin
          send_idle_pct  = 86;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 86;
        end
        default: begin
          send_idle_pct  = 30;
          recv_stall_pct = 30;
        end
      endcase
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) make_string();
    end

    recv_stall_pct = 0;
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
